@@ hw/rtl/b64v_pkg.sv @@
`timescale 1ns / 1ps

package b64v_pkg;

  localparam int SymW   = 6;
  localparam int CharW  = 7;
  localparam int GroupN = 4;

  localparam logic [CharW-1:0] PAD_CHAR    = 7'h3D;
  localparam logic [CharW-1:0] UPPER_BASE  = 7'h41;
  localparam logic [CharW-1:0] LOWER_BASE  = 7'h47;  // 'a' minus 26
  localparam logic [CharW-1:0] DIGIT_SHIFT = 7'h04;  // 52 minus '0'
  localparam logic [CharW-1:0] PLUS_CHAR   = 7'h2B;
  localparam logic [CharW-1:0] MINUS_CHAR  = 7'h2D;

  // Four ready-made characters of one group and the end-of-message mark.
  typedef struct packed {
    logic [GroupN-1:0][CharW-1:0] chars;
    logic                         fin;
  } b64v_group_t;

  // Alphabet A-Z, a-z, 0-9, '+', '-'.
  function automatic logic [CharW-1:0] sym_char(input logic [SymW-1:0] v);
    logic [CharW-1:0] c;
    c = {1'b0, v};
    case (v) inside
      [6'd0:6'd25]:  sym_char = c + UPPER_BASE;
      [6'd26:6'd51]: sym_char = c + LOWER_BASE;
      [6'd52:6'd61]: sym_char = c - DIGIT_SHIFT;
      6'd62:         sym_char = PLUS_CHAR;
      default:       sym_char = MINUS_CHAR;
    endcase
  endfunction

endpackage

@@ hw/rtl/b64v_in_if.sv @@
`timescale 1ns / 1ps

interface b64v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

@@ hw/rtl/b64v_out_if.sv @@
`timescale 1ns / 1ps

interface b64v_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       run_end;
  logic       message_end;

  modport source (output valid, output out_char, output run_end, output message_end,
                  input ready);
  modport sink (input valid, input out_char, input run_end, input message_end,
                output ready);
endinterface

@@ hw/rtl/base64_variant_encoder.sv @@
`timescale 1ns / 1ps

// Streaming Base64-style encoder, value 62 is '+' and value 63 is '-'.
// data_in takes one byte per word with final_byte marking the last byte
// of a message. char_out gives one ASCII character per word; run_end
// marks the fourth character of each group and message_end the last
// character of the message. Groups of three bytes give four characters;
// a final partial group is zero-filled and padded with '=' to four.
// A byte that completes a group is registered into a group register; the
// character register loads it from there once the emitter is free. Bytes
// that do not complete a group are taken every cycle unless a completed
// group is left waiting. One group register waits behind the output
// register of four characters, so a new group is taken as the previous
// fourth character leaves: sustained throughput is one character per
// cycle while char_out is ready, set by the single output character per
// cycle. When char_out stalls, the output holds and data_in.ready drops
// once a completed group is waiting. Reset empties both registers and
// clears the pending byte count.

module base64_variant_encoder
  import b64v_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  b64v_in_if.sink    data_in,
  b64v_out_if.source char_out
);

  logic        grp_valid;
  logic        grp_take;
  b64v_group_t grp;

  b64v_group u_group (
    .clk       (clk),
    .rst       (rst),
    .data_in   (data_in),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_take  (grp_take)
  );

  b64v_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_take  (grp_take),
    .char_out  (char_out)
  );

endmodule

@@ hw/rtl/b64v_group.sv @@
`timescale 1ns / 1ps

module b64v_group
  import b64v_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  b64v_in_if.sink      data_in,
  output logic         grp_valid,
  output b64v_group_t  grp,
  input  logic         grp_take
);

  logic [7:0]  held_first;
  logic [7:0]  held_second;
  logic [1:0]  group_fill;
  logic [1:0]  fill_eff;
  logic        accept;
  logic        complete;
  logic [7:0]  b0, b1, b2;
  logic [GroupN-1:0][SymW-1:0] sext;
  logic [2:0]  nsym;
  b64v_group_t grp_next;

  assign data_in.ready = !grp_valid || grp_take;
  assign accept        = data_in.valid && data_in.ready;

  // A count of three cannot arise; treat it as two.
  assign fill_eff = (group_fill == 2'd3) ? 2'd2 : group_fill;
  assign complete = (fill_eff == 2'd2) || data_in.final_byte;

  always_comb begin
    b0 = (fill_eff == 2'd0) ? data_in.data_byte : held_first;
    b1 = (fill_eff == 2'd0) ? 8'd0 :
         (fill_eff == 2'd1) ? data_in.data_byte : held_second;
    b2 = (fill_eff == 2'd2) ? data_in.data_byte : 8'd0;

    sext[0] = b0[7:2];
    sext[1] = {b0[1:0], b1[7:4]};
    sext[2] = {b1[3:0], b2[7:6]};
    sext[3] = b2[5:0];

    nsym = {1'b0, fill_eff} + 3'd2;
    for (int k = 0; k < GroupN; k++) begin
      grp_next.chars[k] = (3'(k) < nsym) ? sym_char(sext[k]) : PAD_CHAR;
    end
    grp_next.fin = data_in.final_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_fill  <= 2'd0;
      held_first  <= 8'd0;
      held_second <= 8'd0;
      grp_valid   <= 1'b0;
    end else begin
      if (grp_take) grp_valid <= 1'b0;
      if (accept) begin
        if (complete) begin
          group_fill <= 2'd0;
          grp_valid  <= 1'b1;
        end else begin
          if (fill_eff == 2'd0) held_first <= data_in.data_byte;
          else held_second <= data_in.data_byte;
          group_fill <= fill_eff + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && complete) grp <= grp_next;
  end

endmodule

@@ hw/rtl/b64v_emit.sv @@
`timescale 1ns / 1ps

module b64v_emit
  import b64v_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         grp_valid,
  input  b64v_group_t  grp,
  output logic         grp_take,
  b64v_out_if.source   char_out
);

  logic                         busy;
  logic [1:0]                   idx;
  logic [GroupN-1:0][CharW-1:0] chars;
  logic                         fin;
  logic                         fire;
  logic                         last;

  assign fire     = busy && char_out.ready;
  assign last     = fire && (idx == 2'd3);
  assign grp_take = grp_valid && (!busy || last);

  assign char_out.valid       = busy;
  assign char_out.out_char    = chars[idx];
  assign char_out.run_end     = (idx == 2'd3);
  assign char_out.message_end = fin && (idx == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (grp_take) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (fire) begin
      // drop back to idle after the fourth word
      if (idx == 2'd3) busy <= 1'b0;
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_take) begin
      chars <= grp.chars;
      fin   <= grp.fin;
    end
  end

  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    !busy |-> idx == 2'd0)
    else $error("index not at start while idle");

  a_take_load: assert property (@(posedge clk) disable iff (rst)
    grp_take |=> busy && idx == 2'd0)
    else $error("group take did not start a new run");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    busy && !char_out.ready |=> busy && $stable(idx))
    else $error("run advanced while stalled");

  a_take_free: assert property (@(posedge clk) disable iff (rst)
    grp_take && busy |-> last)
    else $error("group taken while a run was in progress");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb
  import b64v_pkg::*;
;

  localparam int ItemTarget = 330;
  localparam int CycleLimit = 400000;

  typedef struct {
    logic [6:0] ch;
    logic       run_end;
    logic       message_end;
  } char_exp_t;

  typedef struct {
    logic [7:0]      data;
    logic            fin;
    bit              has_text;
    logic [3:0][6:0] text;
  } byte_row_t;

  logic clk;
  logic rst;

  b64v_in_if  data_in ();
  b64v_out_if char_out ();

  base64_variant_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .data_in  (data_in),
    .char_out (char_out)
  );

  // Encoder state mirror
  logic [7:0] held_a;
  logic [7:0] held_b;
  logic [1:0] fill;

  char_exp_t char_q[$];
  byte_row_t rows[$];
  int        errors;
  int        cycles;
  int        stall_left;
  bit        calm_rx;
  bit        calm_tx;
  char_exp_t got_exp;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
  endtask

  function automatic logic [6:0] sym_to_ascii(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) c = 8'h41 + 8'(v);                 // 'A'
    else if (v < 6'd52) c = 8'h61 + 8'(v) - 8'd26;   // 'a'
    else if (v < 6'd62) c = 8'h30 + 8'(v) - 8'd52;   // '0'
    else if (v == 6'd62) c = 8'h2b;                  // '+'
    else c = 8'h2d;                                  // '-'
    return c[6:0];
  endfunction

  task automatic encode_byte(input logic [7:0] b, input logic fin, output bit done,
                             output logic [3:0][6:0] chars);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [5:0] s [4];
    int         nsym;
    chars = '0;
    done  = 1'b0;
    if (fill < 2'd2 && !fin) begin
      if (fill == 2'd0) held_a = b;
      else held_b = b;
      fill = fill + 2'd1;
      return;
    end
    b0 = (fill == 2'd0) ? b : held_a;
    b1 = (fill == 2'd0) ? 8'h00 : ((fill == 2'd1) ? b : held_b);
    b2 = (fill == 2'd2) ? b : 8'h00;
    s[0] = b0[7:2];
    s[1] = {b0[1:0], b1[7:4]};
    s[2] = {b1[3:0], b2[7:6]};
    s[3] = b2[5:0];
    nsym = int'(fill) + 2;
    for (int k = 0; k < 4; k++) begin
      chars[k] = (k < nsym) ? sym_to_ascii(s[k]) : PAD_CHAR;
    end
    held_a = '0;
    held_b = '0;
    fill   = '0;
    done   = 1'b1;
  endtask

  task automatic add_row(input logic [7:0] data, input logic fin, input string s);
    byte_row_t r;
    byte       c;
    r.data     = data;
    r.fin      = fin;
    r.has_text = (s.len() == 4);
    r.text     = '0;
    if (r.has_text) begin
      for (int k = 0; k < 4; k++) begin
        c         = s[k];
        r.text[k] = c[6:0];
      end
    end
    rows.push_back(r);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_tx || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic send_byte(input logic [7:0] data, input logic fin, input bit has_text,
                           input logic [3:0][6:0] text);
    int              gap;
    bit              done;
    logic [3:0][6:0] g;
    char_exp_t       e;
    gap = pick_gap();
    if (gap > 0) begin
      data_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data_in.valid      <= 1'b1;
    data_in.data_byte  <= data;
    data_in.final_byte <= fin;
    @(posedge clk);
    while (!data_in.ready) @(posedge clk);
    encode_byte(data, fin, done, g);
    if (done) begin
      if (has_text) g = text;
      for (int k = 0; k < 4; k++) begin
        e.ch          = g[k];
        e.run_end     = (k == 3);
        e.message_end = fin && (k == 3);
        char_q.push_back(e);
      end
    end
  endtask

  // Output side: random stalls, with calm stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) calm_rx = !calm_rx;
    if (stall_left > 0) begin
      stall_left--;
      char_out.ready <= 1'b0;
    end else if (!calm_rx && $urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      stall_left--;
      char_out.ready <= 1'b0;
    end else begin
      char_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (!rst && char_out.valid && char_out.ready) begin
      if (char_q.size() == 0) begin
        report("char with nothing pending", char_out.out_char, 0);
      end else begin
        got_exp = char_q.pop_front();
        if (char_out.out_char !== got_exp.ch)
          report("out_char", char_out.out_char, got_exp.ch);
        if (char_out.run_end !== got_exp.run_end)
          report("run_end", char_out.run_end, got_exp.run_end);
        if (char_out.message_end !== got_exp.message_end)
          report("message_end", char_out.message_end, got_exp.message_end);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int sent;
    int len;
    int r;
    rst                = 1'b1;
    data_in.valid      = 1'b0;
    data_in.data_byte  = '0;
    data_in.final_byte = 1'b0;
    char_out.ready     = 1'b0;
    held_a     = '0;
    held_b     = '0;
    fill       = '0;
    errors     = 0;
    cycles     = 0;
    stall_left = 0;
    calm_rx    = 1'b0;
    calm_tx    = 1'b0;

    // single-byte and two-byte groups at the extremes
    add_row(8'h00, 1'b1, "AA==");
    add_row(8'hff, 1'b1, "-w==");
    add_row(8'h00, 1'b0, "");
    add_row(8'h00, 1'b1, "AAA=");
    add_row(8'hff, 1'b0, "");
    add_row(8'hff, 1'b1, "--8=");
    // two full groups in one message, message_end only on the second
    add_row(8'h00, 1'b0, "");
    add_row(8'h00, 1'b0, "");
    add_row(8'h00, 1'b0, "AAAA");
    add_row(8'hff, 1'b0, "");
    add_row(8'hff, 1'b0, "");
    add_row(8'hff, 1'b1, "----");
    add_row(8'h4d, 1'b0, "");
    add_row(8'h61, 1'b0, "");
    add_row(8'h6e, 1'b1, "TWFu");
    // every symbol is 62, then a padded tail in the same message
    add_row(8'hfb, 1'b0, "");
    add_row(8'hef, 1'b0, "");
    add_row(8'hbe, 1'b0, "++++");
    add_row(8'h80, 1'b1, "");
    add_row(8'ha5, 1'b0, "");
    add_row(8'h5a, 1'b1, "");

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    sent = 0;
    foreach (rows[i]) begin
      send_byte(rows[i].data, rows[i].fin, rows[i].has_text, rows[i].text);
      sent++;
    end

    while (sent < ItemTarget) begin
      if ($urandom_range(0, 7) == 0) calm_tx = !calm_tx;
      r = $urandom_range(0, 99);
      if (r < 60) len = $urandom_range(1, 6);
      else if (r < 92) len = $urandom_range(7, 15);
      else len = $urandom_range(16, 48);
      // trim the last message so the total lands on the target
      if (len > ItemTarget - sent) len = ItemTarget - sent;
      for (int j = 0; j < len; j++) begin
        send_byte(8'($urandom), j == len - 1, 1'b0, '0);
        sent++;
      end
    end
    data_in.valid <= 1'b0;

    while (char_q.size() != 0) @(posedge clk);
    // catch any stray characters after the last group
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
